// ===== design/ttst_pkg.sv =====
// Shared types and constants for the typed timeout slot table.
package ttst_pkg;

    localparam int SLOTS  = 8;
    localparam int IDX_W  = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int KIND_W = 4;
    localparam int CNT_W  = 32;
    localparam int MODE_W = 3;
    localparam int SLOT_W = 3;

    typedef enum logic [MODE_W-1:0] {
        MODE_TICK  = 3'd0,
        MODE_SET   = 3'd1,
        MODE_CLEAR = 3'd2,
        MODE_QEXP  = 3'd3,
        MODE_QRUN  = 3'd4,
        MODE_RESET = 3'd5
    } mode_t;

    typedef enum logic [1:0] {
        ST_IDLE = 2'd0,
        ST_EXEC = 2'd1,
        ST_RESP = 2'd2
    } state_t;

    // controller to datapath
    typedef struct packed {
        logic load;
        logic exec;
    } dp_cmd_t;

endpackage

// ===== design/typed_timeout_slot_table_core.sv =====
// Typed timeout slot table: top level joining sequencer and slot datapath.
//
// A request is taken on a rising edge with start high and busy low; mode,
// timeout_type and offset are sampled on that edge. Modes: tick, set, clear,
// query expired, query running, reset all.
// The request is executed in the next cycle (busy high): the lookup over all
// slots, the table update and, for a tick, the countdown of every armed,
// unexpired slot happen in that cycle. In the cycle after, done is high for
// exactly one cycle with ok, running, expired and slot; the result is taken at
// the edge that ends that cycle and the receiver cannot hold it off.
// A new request may be issued during the done cycle; it then goes straight
// to execution, with no idle state between. Result ports are meaningful
// only while done is high.
// rst_n (asynchronous, active low) frees every slot and returns the block to
// idle; no sweep is needed after reset.
module typed_timeout_slot_table_core
    import ttst_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    output logic              done,
    input  logic [MODE_W-1:0] mode,
    input  logic [KIND_W-1:0] timeout_type,
    input  logic [CNT_W-1:0]  offset,
    output logic              ok,
    output logic              running,
    output logic              expired,
    output logic [SLOT_W-1:0] slot
);

    dp_cmd_t cmd;

    ttst_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .done  (done),
        .cmd   (cmd)
    );

    ttst_dp u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .mode         (mode),
        .timeout_type (timeout_type),
        .offset       (offset),
        .ok           (ok),
        .running      (running),
        .expired      (expired),
        .slot         (slot)
    );

    a_accept_runs: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("accepted request did not start execution");

    a_exec_then_done: assert property (@(posedge clk) disable iff (!rst_n)
        busy |=> (done && !busy))
        else $error("execution not followed by result strobe");

    a_expired_found: assert property (@(posedge clk) disable iff (!rst_n)
        (done && expired) |-> (running && !ok))
        else $error("expired reported for a type that was not armed");

    a_ok_not_expired: assert property (@(posedge clk) disable iff (!rst_n)
        (done && ok) |-> !expired)
        else $error("ok and expired both set");

endmodule

// ===== design/ttst_ctrl.sv =====
// Request sequencer for the typed timeout slot table.
module ttst_ctrl
    import ttst_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    start,
    output logic    busy,
    output logic    done,
    output dp_cmd_t cmd
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                state_next = ST_RESP;
            end
            ST_RESP:
            begin
                // a new request may be taken while the result is shown
                state_next = start ? ST_EXEC : ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        busy     = 1'b0;
        done     = 1'b0;
        cmd.exec = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                busy = 1'b0;
            end
            ST_EXEC:
            begin
                busy     = 1'b1;
                cmd.exec = 1'b1;
            end
            ST_RESP:
            begin
                done = 1'b1;
            end
            default:
            begin
                busy = 1'b0;
            end
        endcase
        cmd.load = start && !busy;
    end

endmodule

// ===== design/ttst_dp.sv =====
// Slot bank, lookup and per-slot countdown lanes.
module ttst_dp
    import ttst_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  dp_cmd_t           cmd,
    input  logic [MODE_W-1:0] mode,
    input  logic [KIND_W-1:0] timeout_type,
    input  logic [CNT_W-1:0]  offset,
    output logic              ok,
    output logic              running,
    output logic              expired,
    output logic [SLOT_W-1:0] slot
);

    // request register
    logic [MODE_W-1:0] mode_reg;
    logic [KIND_W-1:0] type_reg;
    logic [CNT_W-1:0]  offset_reg;

    // slot bank
    logic [KIND_W-1:0] kind_reg [SLOTS];
    logic [KIND_W-1:0] kind_next [SLOTS];
    logic [CNT_W-1:0]  rem_reg [SLOTS];
    logic [CNT_W-1:0]  rem_next [SLOTS];
    logic              exp_reg [SLOTS];
    logic              exp_next [SLOTS];

    // result register
    logic              ok_reg;
    logic              ok_next;
    logic              run_reg;
    logic              run_next;
    logic              expd_reg;
    logic              expd_next;
    logic [SLOT_W-1:0] slot_reg;
    logic [SLOT_W-1:0] slot_next;

    logic              hit;
    logic [IDX_W-1:0]  hit_idx;
    logic              has_free;
    logic [IDX_W-1:0]  free_idx;
    logic [IDX_W+SLOT_W-1:0] hit_ext;
    logic [IDX_W+SLOT_W-1:0] free_ext;

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            mode_reg   <= mode;
            type_reg   <= timeout_type;
            offset_reg <= offset;
        end
    end

    // lowest matching slot and lowest free slot
    always_comb
    begin
        hit      = 1'b0;
        hit_idx  = '0;
        has_free = 1'b0;
        free_idx = '0;
        for (int i = SLOTS - 1; i >= 0; i--)
        begin
            if (type_reg != '0 && kind_reg[i] == type_reg)
            begin
                hit     = 1'b1;
                hit_idx = IDX_W'(i);
            end
            if (kind_reg[i] == '0)
            begin
                has_free = 1'b1;
                free_idx = IDX_W'(i);
            end
        end
        hit_ext  = {{SLOT_W{1'b0}}, hit_idx};
        free_ext = {{SLOT_W{1'b0}}, free_idx};
    end

    always_comb
    begin
        kind_next = kind_reg;
        rem_next  = rem_reg;
        exp_next  = exp_reg;
        ok_next   = 1'b0;
        run_next  = hit;
        expd_next = 1'b0;
        slot_next = '0;
        case (mode_t'(mode_reg))
            MODE_TICK:
            begin
                for (int i = 0; i < SLOTS; i++)
                begin
                    if (kind_reg[i] != '0 && !exp_reg[i])
                    begin
                        if (rem_reg[i] <= CNT_W'(1))
                        begin
                            rem_next[i] = '0;
                            exp_next[i] = 1'b1;
                        end
                        else
                        begin
                            rem_next[i] = rem_reg[i] - CNT_W'(1);
                        end
                    end
                end
            end
            MODE_SET:
            begin
                if (type_reg != '0 && !hit && has_free)
                begin
                    kind_next[free_idx] = type_reg;
                    rem_next[free_idx]  = offset_reg;
                    exp_next[free_idx]  = 1'b0;
                    ok_next             = 1'b1;
                    slot_next           = free_ext[SLOT_W-1:0];
                end
            end
            MODE_CLEAR:
            begin
                if (hit)
                begin
                    kind_next[hit_idx] = '0;
                    rem_next[hit_idx]  = '0;
                    exp_next[hit_idx]  = 1'b0;
                    ok_next            = 1'b1;
                    slot_next          = hit_ext[SLOT_W-1:0];
                end
            end
            MODE_QEXP:
            begin
                if (hit)
                begin
                    slot_next = hit_ext[SLOT_W-1:0];
                    if (exp_reg[hit_idx])
                    begin
                        expd_next          = 1'b1;
                        kind_next[hit_idx] = '0;
                        rem_next[hit_idx]  = '0;
                        exp_next[hit_idx]  = 1'b0;
                    end
                end
            end
            MODE_QRUN:
            begin
                if (hit)
                begin
                    slot_next = hit_ext[SLOT_W-1:0];
                end
            end
            MODE_RESET:
            begin
                for (int i = 0; i < SLOTS; i++)
                begin
                    kind_next[i] = '0;
                    rem_next[i]  = '0;
                    exp_next[i]  = 1'b0;
                end
            end
            default:
            begin
                ok_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < SLOTS; i++)
            begin
                kind_reg[i] <= '0;
                rem_reg[i]  <= '0;
                exp_reg[i]  <= 1'b0;
            end
        end
        else if (cmd.exec)
        begin
            kind_reg <= kind_next;
            rem_reg  <= rem_next;
            exp_reg  <= exp_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.exec)
        begin
            ok_reg   <= ok_next;
            run_reg  <= run_next;
            expd_reg <= expd_next;
            slot_reg <= slot_next;
        end
    end

    assign ok      = ok_reg;
    assign running = run_reg;
    assign expired = expd_reg;
    assign slot    = slot_reg;

endmodule
